FILE: src/osm_pkg.sv
// Shared types and constants for the order-statistic multiset unit.
`default_nettype none
package osm_pkg;
    localparam int CAPACITY   = 1024;
    localparam int COUNT_BITS = 16;
    localparam int ADDR_BITS  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int USED_BITS  = ADDR_BITS + 1;

    localparam logic [2:0] CMD_RANK   = 3'd0;
    localparam logic [2:0] CMD_KTH    = 3'd1;
    localparam logic [2:0] CMD_PRED   = 3'd2;
    localparam logic [2:0] CMD_SUCC   = 3'd3;
    localparam logic [2:0] CMD_INSERT = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_PRED = 2'd1;
    localparam logic [1:0] ST_K_RANGE = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    localparam logic signed [31:0] SENTINEL     = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] NO_PRED_VAL  = -32'sh7FFF_FFFF;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic signed [31:0]    value;
        logic [COUNT_BITS-1:0] count;
    } t_entry;
endpackage
`default_nettype wire

FILE: src/osm_ram.sv
// Table memory of distinct values and counts, one write and one registered read port.
`default_nettype none
module osm_ram (
    input  wire logic                           i_clk,
    input  wire logic                           i_we,
    input  wire logic [osm_pkg::ADDR_BITS-1:0]  i_waddr,
    input  wire osm_pkg::t_entry                i_wdata,
    input  wire logic [osm_pkg::ADDR_BITS-1:0]  i_raddr,
    output osm_pkg::t_entry                     o_rdata
);
    osm_pkg::t_entry r_mem [osm_pkg::CAPACITY];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: src/order_statistic_multiset_unit.sv
// Top level of the order-statistic multiset unit: command sequencer around the table memory.
// A query walks the table from entry 0, through a read state and an evaluate state per entry
// visited; an insert of a new value then moves each later entry up one place and puts it in.
// Throughput: one word at a time; the next word is taken once the previous one is finished,
// so the time per word is the walk above, held longer while the result word is stalled.
// Reset: i_rst_n is synchronous, active low, and empties the table at once (no clearing pass).
`default_nettype none
module order_statistic_multiset_unit (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [2:0]         i_command,
    input  wire logic signed [31:0] i_operand,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic signed [31:0]      o_answer,
    output logic [1:0]              o_status
);
    localparam int AW = osm_pkg::ADDR_BITS;
    localparam int UW = osm_pkg::USED_BITS;
    localparam int CB = osm_pkg::COUNT_BITS;

    typedef enum logic [2:0] {
        S_IDLE, S_RD, S_EVAL, S_SH_RD, S_SH_WR, S_PUT, S_EMIT
    } t_state;

    t_state                r_state;
    logic [2:0]            r_cmd;
    logic signed [31:0]    r_x;
    logic [UW-1:0]         r_used;
    logic [31:0]           r_total;
    logic [UW-1:0]         r_idx;     // scan position, also the shift pointer
    logic [UW-1:0]         r_pos;     // insertion point
    logic [31:0]           r_sum;     // rank accumulator, saturates at 2^31-1
    logic [32:0]           r_cum;     // running count for k-th, saturates at 2^32
    logic                  r_found;
    logic signed [31:0]    r_pred;
    logic signed [31:0]    r_res_ans;
    logic [1:0]            r_res_st;

    // Memory port signals.
    logic                  w_we;
    logic [AW-1:0]         w_waddr;
    osm_pkg::t_entry       w_wdata;
    logic [AW-1:0]         w_raddr;
    osm_pkg::t_entry       w_rdata;

    osm_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign o_in_ready = (r_state == S_IDLE);

    // Saturating accumulations for the entry now on the read port.
    logic [32:0] w_sum_add;
    logic [31:0] w_sum_next;
    logic [33:0] w_cum_add;
    logic [32:0] w_cum_next;
    logic [32:0] w_k;
    logic [32:0] w_total_p1;
    logic [31:0] w_total_inc;

    always_comb begin
        w_sum_add   = {1'b0, r_sum} + 33'(w_rdata.count);
        w_sum_next  = (w_sum_add > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : w_sum_add[31:0];
        w_cum_add   = {1'b0, r_cum} + 34'(w_rdata.count);
        w_cum_next  = (w_cum_add > 34'h1_0000_0000) ? 33'h1_0000_0000 : w_cum_add[32:0];
        w_k         = {1'b0, i_operand};
        w_total_p1  = {1'b0, r_total} + 33'd1;
        w_total_inc = (r_total == 32'hFFFF_FFFF) ? r_total : r_total + 32'd1;
    end

    // Memory access is decided by the state, and in the evaluate state also by the command and the entry read.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_idx[AW-1:0];
        w_wdata = w_rdata;
        w_raddr = r_idx[AW-1:0];
        case (r_state)
            S_EVAL: begin
                // An insert that hits an existing value bumps its count in place, unless the count is saturated.
                if (r_cmd == osm_pkg::CMD_INSERT && w_rdata.value == r_x
                        && w_rdata.count != osm_pkg::COUNT_MAX) begin
                    w_we          = 1'b1;
                    w_wdata.count = w_rdata.count + CB'(1);
                end
            end
            S_SH_RD: begin
                w_raddr = AW'(r_idx - UW'(1));
            end
            S_SH_WR: begin
                // Move the entry read last cycle one place up.
                w_we = 1'b1;
            end
            S_PUT: begin
                w_we          = 1'b1;
                w_waddr       = r_pos[AW-1:0];
                w_wdata.value = r_x;
                w_wdata.count = CB'(1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_total     <= '0;
            o_out_valid <= 1'b0;
        end else begin
            // A word leaving the output register frees it, unless the next one takes its place.
            if (o_out_valid && i_out_ready && r_state != S_EMIT) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_cmd   <= i_command;
                        r_x     <= i_operand;
                        r_idx   <= '0;
                        r_sum   <= 32'd1;
                        r_cum   <= '0;
                        r_found <= 1'b0;
                        if (i_command > osm_pkg::CMD_INSERT) begin
                            r_state <= S_IDLE;
                        end else if (i_command == osm_pkg::CMD_KTH
                                && (i_operand <= 0 || w_k > w_total_p1)) begin
                            r_res_ans <= '0;
                            r_res_st  <= osm_pkg::ST_K_RANGE;
                            r_state   <= S_EMIT;
                        end else begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    if (r_idx == r_used) begin
                        // Walked off the end of the table.
                        case (r_cmd)
                            osm_pkg::CMD_RANK: begin
                                r_res_ans <= r_sum;
                                r_res_st  <= osm_pkg::ST_OK;
                                r_state   <= S_EMIT;
                            end
                            osm_pkg::CMD_PRED: begin
                                r_res_ans <= r_found ? r_pred : osm_pkg::NO_PRED_VAL;
                                r_res_st  <= r_found ? osm_pkg::ST_OK : osm_pkg::ST_NO_PRED;
                                r_state   <= S_EMIT;
                            end
                            osm_pkg::CMD_INSERT: begin
                                if (r_used >= UW'(osm_pkg::CAPACITY)) begin
                                    r_res_ans <= '0;
                                    r_res_st  <= osm_pkg::ST_FULL;
                                    r_state   <= S_EMIT;
                                end else begin
                                    r_pos   <= r_used;
                                    r_state <= S_PUT;
                                end
                            end
                            default: begin
                                r_res_ans <= osm_pkg::SENTINEL;
                                r_res_st  <= osm_pkg::ST_OK;
                                r_state   <= S_EMIT;
                            end
                        endcase
                    end else begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    case (r_cmd)
                        osm_pkg::CMD_RANK: begin
                            if (w_rdata.value < r_x) begin
                                r_sum   <= w_sum_next;
                                r_idx   <= r_idx + UW'(1);
                                r_state <= S_RD;
                            end else begin
                                r_res_ans <= r_sum;
                                r_res_st  <= osm_pkg::ST_OK;
                                r_state   <= S_EMIT;
                            end
                        end
                        osm_pkg::CMD_KTH: begin
                            r_cum <= w_cum_next;
                            if ({1'b0, r_x} <= w_cum_next) begin
                                r_res_ans <= w_rdata.value;
                                r_res_st  <= osm_pkg::ST_OK;
                                r_state   <= S_EMIT;
                            end else begin
                                r_idx   <= r_idx + UW'(1);
                                r_state <= S_RD;
                            end
                        end
                        osm_pkg::CMD_PRED: begin
                            if (w_rdata.value < r_x) begin
                                r_pred  <= w_rdata.value;
                                r_found <= 1'b1;
                                r_idx   <= r_idx + UW'(1);
                                r_state <= S_RD;
                            end else begin
                                r_res_ans <= r_found ? r_pred : osm_pkg::NO_PRED_VAL;
                                r_res_st  <= r_found ? osm_pkg::ST_OK : osm_pkg::ST_NO_PRED;
                                r_state   <= S_EMIT;
                            end
                        end
                        osm_pkg::CMD_SUCC: begin
                            if (w_rdata.value > r_x) begin
                                r_res_ans <= w_rdata.value;
                                r_res_st  <= osm_pkg::ST_OK;
                                r_state   <= S_EMIT;
                            end else begin
                                r_idx   <= r_idx + UW'(1);
                                r_state <= S_RD;
                            end
                        end
                        default: begin
                            if (w_rdata.value == r_x) begin
                                if (w_rdata.count != osm_pkg::COUNT_MAX) begin
                                    r_total <= w_total_inc;
                                end
                                r_state <= S_IDLE;
                            end else if (w_rdata.value > r_x) begin
                                if (r_used >= UW'(osm_pkg::CAPACITY)) begin
                                    r_res_ans <= '0;
                                    r_res_st  <= osm_pkg::ST_FULL;
                                    r_state   <= S_EMIT;
                                end else begin
                                    r_pos   <= r_idx;
                                    r_idx   <= r_used;
                                    r_state <= S_SH_RD;
                                end
                            end else begin
                                r_idx   <= r_idx + UW'(1);
                                r_state <= S_RD;
                            end
                        end
                    endcase
                end
                S_SH_RD: begin
                    r_state <= (r_idx == r_pos) ? S_PUT : S_SH_WR;
                end
                S_SH_WR: begin
                    r_idx   <= r_idx - UW'(1);
                    r_state <= S_SH_RD;
                end
                S_PUT: begin
                    r_used  <= r_used + UW'(1);
                    r_total <= w_total_inc;
                    r_state <= S_IDLE;
                end
                S_EMIT: begin
                    // Hand the word over once the output register is free.
                    if (!o_out_valid || i_out_ready) begin
                        o_out_valid <= 1'b1;
                        o_answer    <= r_res_ans;
                        o_status    <= r_res_st;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: src/osm_checker.sv
// Port-level checks for the order-statistic multiset unit, bound to the top level.
`default_nettype none
module osm_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire logic signed [31:0] o_answer,
    input wire logic [1:0]         o_status
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_answer) && $stable(o_status))
        else $error("result word changed while stalled");

    a_no_pred: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == osm_pkg::ST_NO_PRED |-> o_answer == osm_pkg::NO_PRED_VAL)
        else $error("missing predecessor with wrong answer");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == osm_pkg::ST_K_RANGE || o_status == osm_pkg::ST_FULL)
        |-> o_answer == 32'sd0)
        else $error("error word with nonzero answer");

    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");
endmodule

bind order_statistic_multiset_unit osm_checker u_osm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_answer    (o_answer),
    .o_status    (o_status)
);
`default_nettype wire

FILE: tb/osm_checker.sv
// Checker for the order-statistic multiset unit: watches both channels, predicts and compares.
`timescale 1ns / 1ps
module osm_scoreboard (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_ready,
    input  wire logic [2:0]         i_command,
    input  wire logic signed [31:0] i_operand,
    input  wire logic               i_out_valid,
    input  wire logic               i_out_ready,
    input  wire logic signed [31:0] i_answer,
    input  wire logic [1:0]         i_status,
    output int                      o_errors,
    output int                      o_pending
);
    // Shadow of the table: distinct values ascending, with their counts.
    logic signed [31:0] shadow_vals[$];
    int unsigned        shadow_cnts[$];
    longint unsigned    shadow_total;

    // Answers and statuses still owed by the block, oldest first.
    logic signed [31:0] owed_answer[$];
    logic [1:0]         owed_status[$];

    initial begin
        o_errors     = 0;
        o_pending    = 0;
        shadow_total = 0;
    end

    function automatic int first_not_below(logic signed [31:0] x);
        int n;
        n = 0;
        while (n < shadow_vals.size() && shadow_vals[n] < x) n++;
        return n;
    endfunction

    task automatic apply_word(logic [2:0] cmd, logic signed [31:0] x);
        int              pos;
        longint unsigned acc;
        longint          kk;
        logic            has;
        logic signed [31:0] ans;
        logic [1:0]      st;
        has = 1'b1;
        ans = '0;
        st  = osm_pkg::ST_OK;
        pos = first_not_below(x);
        case (cmd)
            osm_pkg::CMD_RANK: begin
                acc = 1;
                for (int i = 0; i < pos; i++) acc += shadow_cnts[i];
                if (acc > 64'd2147483647) acc = 64'd2147483647;
                ans = acc[31:0];
            end
            osm_pkg::CMD_KTH: begin
                kk = x;
                if (kk <= 0 || kk > longint'(shadow_total) + 1) begin
                    st = osm_pkg::ST_K_RANGE;
                end else begin
                    ans = osm_pkg::SENTINEL;
                    acc = 0;
                    for (int i = 0; i < shadow_vals.size(); i++) begin
                        acc += shadow_cnts[i];
                        if (kk <= longint'(acc)) begin
                            ans = shadow_vals[i];
                            break;
                        end
                    end
                end
            end
            osm_pkg::CMD_PRED: begin
                if (pos == 0) begin
                    ans = osm_pkg::NO_PRED_VAL;
                    st  = osm_pkg::ST_NO_PRED;
                end else begin
                    ans = shadow_vals[pos-1];
                end
            end
            osm_pkg::CMD_SUCC: begin
                if (pos < shadow_vals.size() && shadow_vals[pos] == x) pos++;
                ans = (pos < shadow_vals.size()) ? shadow_vals[pos] : osm_pkg::SENTINEL;
            end
            osm_pkg::CMD_INSERT: begin
                has = 1'b0;
                if (pos < shadow_vals.size() && shadow_vals[pos] == x) begin
                    // A saturated count leaves everything unchanged.
                    if (shadow_cnts[pos] < int'(osm_pkg::COUNT_MAX)) begin
                        shadow_cnts[pos]++;
                        if (shadow_total != 64'hFFFF_FFFF) shadow_total++;
                    end
                end else if (shadow_vals.size() >= osm_pkg::CAPACITY) begin
                    has = 1'b1;
                    st  = osm_pkg::ST_FULL;
                end else begin
                    shadow_vals.insert(pos, x);
                    shadow_cnts.insert(pos, 1);
                    if (shadow_total != 64'hFFFF_FFFF) shadow_total++;
                end
            end
            default: has = 1'b0;
        endcase
        if (has) begin
            owed_answer.push_back(ans);
            owed_status.push_back(st);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                if (owed_answer.size() == 0) begin
                    o_errors++;
                    $display("%0t: unexpected word answer=%0d status=%0d",
                             $time, i_answer, i_status);
                end else begin
                    if (i_answer !== owed_answer[0]) begin
                        o_errors++;
                        $display("%0t: answer expected %0d actual %0d",
                                 $time, owed_answer[0], i_answer);
                    end
                    if (i_status !== owed_status[0]) begin
                        o_errors++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, owed_status[0], i_status);
                    end
                    void'(owed_answer.pop_front());
                    void'(owed_status.pop_front());
                end
            end
            if (i_in_valid && i_in_ready) apply_word(i_command, i_operand);
        end
        o_pending = owed_answer.size();
    end
endmodule

FILE: tb/tb.sv
// Testbench top for the order-statistic multiset unit: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module tb;
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [2:0]         command = osm_pkg::CMD_RANK;
    logic signed [31:0] operand = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [31:0] answer;
    logic [1:0]         status;
    int                 errors;
    int                 pending;

    // When set, neither side idles; used for the end of the run.
    bit                 quiet = 1'b0;
    // Rough count of stored items, only used to aim k near the valid range.
    longint             stored_est = 0;
    logic signed [31:0] pool[40];

    order_statistic_multiset_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_command   (command),
        .i_operand   (operand),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_answer    (answer),
        .o_status    (status)
    );

    osm_scoreboard u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_command   (command),
        .i_operand   (operand),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_answer    (answer),
        .i_status    (status),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Result side back-pressure: random stall bursts.
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 9);
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // Present one word and hold it until the block takes it. Valid is only
    // lowered when an idle burst goes in front of the word.
    task automatic push_word(logic [2:0] cmd, logic signed [31:0] val);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        operand  <= val;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        if (cmd == osm_pkg::CMD_INSERT) stored_est++;
    endtask

    function automatic logic signed [31:0] pick_operand();
        logic signed [31:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: v = pool[$urandom_range(0, 39)];
            5:             v = pool[$urandom_range(0, 39)] + $urandom_range(0, 2) - 1;
            6:             v = $urandom_range(0, 1) ? osm_pkg::SENTINEL : 32'sh8000_0000;
            default:       v = $urandom;
        endcase
        return v;
    endfunction

    initial begin
        logic [2:0]         cmd;
        logic signed [31:0] val;
        int                 r;

        foreach (pool[i]) pool[i] = $urandom;
        pool[0] = osm_pkg::SENTINEL;
        pool[1] = 32'sh8000_0000;
        pool[2] = 0;
        pool[3] = -1;
        pool[4] = 1;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty table, bounds of k, missing predecessor, sentinel, repeats, unknown commands.
        push_word(osm_pkg::CMD_RANK, 5);
        push_word(osm_pkg::CMD_KTH, 1);
        push_word(osm_pkg::CMD_KTH, 0);
        push_word(osm_pkg::CMD_KTH, 2);
        push_word(osm_pkg::CMD_KTH, -1);
        push_word(osm_pkg::CMD_KTH, 32'sh8000_0000);
        push_word(osm_pkg::CMD_PRED, 0);
        push_word(osm_pkg::CMD_SUCC, osm_pkg::SENTINEL);
        push_word(osm_pkg::CMD_INSERT, osm_pkg::SENTINEL);
        push_word(osm_pkg::CMD_INSERT, 32'sh8000_0000);
        push_word(osm_pkg::CMD_INSERT, 0);
        push_word(osm_pkg::CMD_INSERT, 0);
        push_word(3'd5, 7);
        push_word(3'd7, -7);
        push_word(osm_pkg::CMD_RANK, osm_pkg::SENTINEL);
        push_word(osm_pkg::CMD_KTH, 4);
        push_word(osm_pkg::CMD_KTH, 5);
        push_word(osm_pkg::CMD_KTH, 6);
        push_word(osm_pkg::CMD_PRED, 32'sh8000_0000);
        push_word(osm_pkg::CMD_PRED, osm_pkg::SENTINEL);
        push_word(osm_pkg::CMD_SUCC, 32'sh8000_0000);
        push_word(osm_pkg::CMD_SUCC, -1);
        push_word(osm_pkg::CMD_SUCC, 0);

        // Random part over a small set of values so the table stays short.
        repeat (770) begin
            r = $urandom_range(0, 99);
            val = pick_operand();
            if (r < 30) begin
                cmd = osm_pkg::CMD_INSERT;
                val = pool[$urandom_range(0, 39)];
            end else if (r < 45) begin
                cmd = osm_pkg::CMD_KTH;
                case ($urandom_range(0, 5))
                    0:       val = $urandom;
                    1:       val = 32'(stored_est + longint'($urandom_range(0, 3)));
                    2:       val = $urandom_range(0, 3) - 1;
                    default: val = $urandom_range(1, 32'(stored_est + 1));
                endcase
            end else if (r < 60) begin
                cmd = osm_pkg::CMD_RANK;
            end else if (r < 75) begin
                cmd = osm_pkg::CMD_PRED;
            end else if (r < 95) begin
                cmd = osm_pkg::CMD_SUCC;
            end else begin
                cmd = 3'($urandom_range(5, 7));
            end
            push_word(cmd, val);
        end

        // Last part, no idling: fill the table with new values until inserts
        // are dropped, then query the full table.
        quiet = 1'b1;
        for (int i = 0; i < 1100; i++) push_word(osm_pkg::CMD_INSERT, (i << 8) | 1);
        push_word(osm_pkg::CMD_INSERT, 32'sh7FFF_FFF0);
        push_word(osm_pkg::CMD_INSERT, 0);
        push_word(osm_pkg::CMD_RANK, osm_pkg::SENTINEL);
        push_word(osm_pkg::CMD_RANK, 300001);
        push_word(osm_pkg::CMD_KTH, 32'(stored_est));
        push_word(osm_pkg::CMD_KTH, 70000);
        push_word(osm_pkg::CMD_PRED, osm_pkg::SENTINEL);
        push_word(osm_pkg::CMD_SUCC, 32'sh8000_0000);
        push_word(osm_pkg::CMD_SUCC, (1023 << 8) | 1);
        in_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (5000) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

    // Watchdog, several times the slowest correct run.
    initial begin
        #40_000_000;
        $display("tb NOT OK");
        $finish;
    end
endmodule
